// File: rtl/gckm_pkg.sv
// gckm_pkg: shared types, codes and the chord table for the chord keyboard mapper
// no dependencies
`default_nettype none
package gckm_pkg;

    localparam int STICK_AXES    = 4;
    localparam int AXIS_W        = $clog2(STICK_AXES);
    localparam int CHORD_ENTRIES = 75;
    localparam int MAX_EV        = 6;
    localparam int EV_W          = $clog2(MAX_EV + 1);

    localparam logic [1:0] MODE_BUTTON = 2'd0;
    localparam logic [1:0] MODE_HAT    = 2'd1;
    localparam logic [1:0] MODE_STICK  = 2'd2;

    localparam logic [3:0] BTN_FACE_S  = 4'd0;
    localparam logic [3:0] BTN_FACE_E  = 4'd1;
    localparam logic [3:0] BTN_FACE_N  = 4'd2;
    localparam logic [3:0] BTN_FACE_W  = 4'd3;
    localparam logic [3:0] BTN_LSHLD   = 4'd4;
    localparam logic [3:0] BTN_RSHLD   = 4'd5;
    localparam logic [3:0] BTN_LTRIG   = 4'd6;
    localparam logic [3:0] BTN_RTRIG   = 4'd7;
    localparam logic [3:0] BTN_VIEW    = 4'd8;
    localparam logic [3:0] BTN_OPTIONS = 4'd9;
    localparam logic [3:0] BTN_PS      = 4'd10;
    localparam logic [3:0] BTN_OTHER   = 4'd11;
    localparam logic [3:0] AXIS_X      = 4'd0;
    localparam logic [3:0] AXIS_Y      = 4'd1;
    localparam logic [3:0] AXIS_RX     = 4'd2;
    localparam logic [3:0] AXIS_RY     = 4'd3;

    localparam logic [3:0] REG_THRESHOLD  = 4'd0;
    localparam logic [3:0] REG_HYSTERESIS = 4'd1;

    localparam logic [7:0] KC_CTRL        = 8'd29;
    localparam logic [7:0] KC_SHIFT       = 8'd42;
    localparam logic [7:0] KC_META        = 8'd125;
    localparam logic [7:0] KC_ALT         = 8'd56;
    localparam logic [7:0] KC_ARROW_LEFT  = 8'd105;
    localparam logic [7:0] KC_ARROW_RIGHT = 8'd106;
    localparam logic [7:0] KC_ARROW_UP    = 8'd103;
    localparam logic [7:0] KC_ARROW_DOWN  = 8'd108;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_L    = 2'd1;
    localparam logic [1:0] SIDE_R    = 2'd2;

    localparam logic [7:0] DL = 8'h01;
    localparam logic [7:0] DR = 8'h02;
    localparam logic [7:0] DU = 8'h04;
    localparam logic [7:0] DD = 8'h08;
    localparam logic [7:0] FW = 8'h10;
    localparam logic [7:0] FE = 8'h20;
    localparam logic [7:0] FN = 8'h40;
    localparam logic [7:0] FS = 8'h80;

    typedef struct packed {
        logic [EV_W-1:0]           cnt;
        logic [MAX_EV-1:0][7:0]    code;
        logic [MAX_EV-1:0]         down;
    } ev_bundle_t;

    function automatic logic [7:0] chord_lookup(input logic [1:0] side, input logic [7:0] mask);
        logic [7:0] r;
        unique case ({side, mask})
            {SIDE_R, FW}: r = 8'd14;           {SIDE_R, FS}: r = 8'd28;
            {SIDE_R, FN}: r = 8'd57;           {SIDE_R, FE}: r = 8'd1;
            {SIDE_L, DD}: r = 8'd127;          {SIDE_L, DL}: r = 8'd15;
            {SIDE_L, DU}: r = 8'd111;          {SIDE_L, DR}: r = 8'd58;
            {SIDE_R, FW|DL}: r = 8'd35;        {SIDE_R, FW|DD}: r = 8'd36;
            {SIDE_R, FW|DU}: r = 8'd37;        {SIDE_R, FW|DR}: r = 8'd38;
            {SIDE_R, FS|DL}: r = 8'd34;        {SIDE_R, FS|DD}: r = 8'd48;
            {SIDE_R, FS|DU}: r = 8'd49;        {SIDE_R, FS|DR}: r = 8'd50;
            {SIDE_R, FN|DL}: r = 8'd24;        {SIDE_R, FN|DD}: r = 8'd25;
            {SIDE_R, FN|DU}: r = 8'd26;        {SIDE_R, FN|DR}: r = 8'd27;
            {SIDE_R, FE|DL}: r = 8'd51;        {SIDE_R, FE|DD}: r = 8'd52;
            {SIDE_R, FE|DU}: r = 8'd39;        {SIDE_R, FE|DR}: r = 8'd40;
            {SIDE_L, DL|FW}: r = 8'd30;        {SIDE_L, DL|FS}: r = 8'd31;
            {SIDE_L, DL|FN}: r = 8'd32;        {SIDE_L, DL|FE}: r = 8'd33;
            {SIDE_L, DU|FW}: r = 8'd16;        {SIDE_L, DU|FS}: r = 8'd17;
            {SIDE_L, DU|FN}: r = 8'd18;        {SIDE_L, DU|FE}: r = 8'd19;
            {SIDE_L, DD|FW}: r = 8'd44;        {SIDE_L, DD|FS}: r = 8'd45;
            {SIDE_L, DD|FN}: r = 8'd46;        {SIDE_L, DD|FE}: r = 8'd47;
            {SIDE_L, DR|FW}: r = 8'd20;        {SIDE_L, DR|FS}: r = 8'd21;
            {SIDE_L, DR|FN}: r = 8'd22;        {SIDE_L, DR|FE}: r = 8'd23;
            {SIDE_R, FW|FS|DL}: r = 8'd63;     {SIDE_R, FW|FS|DU}: r = 8'd64;
            {SIDE_R, FW|FS|DD}: r = 8'd65;     {SIDE_R, FW|FS|DR}: r = 8'd66;
            {SIDE_R, FS|FE|DL}: r = 8'd67;     {SIDE_R, FS|FE|DU}: r = 8'd68;
            {SIDE_R, FS|FE|DD}: r = 8'd87;     {SIDE_R, FS|FE|DR}: r = 8'd88;
            {SIDE_R, FN|FW|DL}: r = 8'd59;     {SIDE_R, FN|FW|DU}: r = 8'd60;
            {SIDE_R, FN|FW|DD}: r = 8'd61;     {SIDE_R, FN|FW|DR}: r = 8'd62;
            {SIDE_R, FE|FN|DL}: r = 8'd102;    {SIDE_R, FE|FN|DU}: r = 8'd104;
            {SIDE_R, FE|FN|DD}: r = 8'd109;    {SIDE_R, FE|FN|DR}: r = 8'd107;
            {SIDE_L, DL|DD|FW}: r = 8'd6;      {SIDE_L, DL|DD|FS}: r = 8'd7;
            {SIDE_L, DL|DD|FN}: r = 8'd8;      {SIDE_L, DL|DD|FE}: r = 8'd9;
            {SIDE_L, DU|DL|FW}: r = 8'd2;      {SIDE_L, DU|DL|FS}: r = 8'd3;
            {SIDE_L, DU|DL|FN}: r = 8'd4;      {SIDE_L, DU|DL|FE}: r = 8'd5;
            {SIDE_L, DD|DR|FW}: r = 8'd10;     {SIDE_L, DD|DR|FS}: r = 8'd11;
            {SIDE_L, DD|DR|FN}: r = 8'd12;     {SIDE_L, DD|DR|FE}: r = 8'd13;
            {SIDE_L, DR|DU|FW}: r = 8'd41;     {SIDE_L, DR|DU|FS}: r = 8'd43;
            {SIDE_L, DR|DU|FN}: r = 8'd53;
            {SIDE_R, FE|FN|DL|DD}: r = 8'd110; {SIDE_R, FE|FN|DU|DL}: r = 8'd70;
            {SIDE_R, FE|FN|DD|DR}: r = 8'd119; {SIDE_R, FE|FN|DR|DU}: r = 8'd99;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gckm_front.sv
// gckm_front: accepts gamepad events, tracks held state and builds the key event list
// depends on gckm_pkg
`default_nettype none
module gckm_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output gckm_pkg::ev_bundle_t    q_data
);
    import gckm_pkg::*;

    logic [6:0] thr_reg;
    logic [5:0] hys_reg;
    logic       kb_reg, kb_next;
    logic [7:0] cb_reg, cb_next;
    logic [3:0] mod_reg, mod_next;
    logic [9:0] misc_reg, misc_next;
    logic       pend_reg, pend_next;
    logic [1:0] side_reg, side_next;
    logic [1:0] lvl_reg [STICK_AXES];
    logic       lvl_we;
    logic [1:0] lvl_new;

    logic [1:0]         kind;
    logic [3:0]         ctl;
    logic signed [8:0]  val;
    logic               accept;

    assign kind     = s_tdata[1:0];
    assign ctl      = s_tdata[5:2];
    assign val      = $signed(s_tdata[14:6]);
    assign s_tready = !q_full;
    assign cfg_ready = 1'b1;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        logic signed [10:0] d, tph, tmh;
        logic       prs, rel, neg, valid;
        logic [1:0] ek, lvl, prv;
        logic [7:0] cc;
        logic [EV_W-1:0] n;
        n = '0;
        cc = '0;
        q_data = '0;
        kb_next = kb_reg; cb_next = cb_reg; mod_next = mod_reg; misc_next = misc_reg;
        pend_next = pend_reg; side_next = side_reg;
        prs = 1'b0; rel = 1'b0; neg = 1'b0; ek = kind; valid = 1'b0;
        lvl = 2'b00; prv = 2'b00; lvl_we = 1'b0;
        d   = $signed({val[8], val[8], val}) - 11'sd127;
        tph = $signed({4'b0, thr_reg}) + $signed({5'b0, hys_reg});
        tmh = $signed({4'b0, thr_reg}) - $signed({5'b0, hys_reg});
        if (kind == MODE_BUTTON) begin
            prs = (val == 9'sd1);
            rel = (val == 9'sd0);
        end else if (kind == MODE_HAT && ctl < 4'd2) begin
            prs = (val == 9'sd1) || (val == -9'sd1);
            rel = (val == 9'sd0);
            neg = val[8];
        end else if (kind == MODE_STICK && ctl < 4'(STICK_AXES)) begin
            prv = lvl_reg[ctl[AXIS_W-1:0]];
            if (d > tph) begin
                lvl = 2'b01; valid = 1'b1;
            end else if (d < -tph) begin
                lvl = 2'b11; valid = 1'b1;
            end else if (d > -tmh && d < tmh) begin
                lvl = 2'b00; valid = 1'b1;
            end
            if (valid && prv != lvl) begin
                lvl_we = 1'b1;
                prs = (lvl != 2'b00);
                rel = (lvl == 2'b00) || (prv != 2'b00);
                neg = lvl[1];
            end
        end
        lvl_new = lvl;

        // release part first, then press part
        if (rel && kb_next) begin
            if (pend_next) begin
                cc = chord_lookup(side_next, cb_next);
                if (cc != 8'd0) begin
                    q_data.code[n] = cc; q_data.down[n] = 1'b1; n = n + 1'b1;
                    q_data.code[n] = cc; q_data.down[n] = 1'b0; n = n + 1'b1;
                end
            end
            if (ek == MODE_BUTTON) begin
                unique case (ctl)
                    BTN_FACE_S: begin cb_next = cb_next & ~FS; pend_next = 1'b0; end
                    BTN_FACE_E: begin cb_next = cb_next & ~FE; pend_next = 1'b0; end
                    BTN_FACE_N: begin cb_next = cb_next & ~FN; pend_next = 1'b0; end
                    BTN_FACE_W: begin cb_next = cb_next & ~FW; pend_next = 1'b0; end
                    BTN_LSHLD: begin
                        if (mod_next[2]) begin
                            q_data.code[n] = KC_META; q_data.down[n] = 1'b0; n = n + 1'b1;
                        end
                        mod_next[2] = 1'b0;
                    end
                    BTN_RSHLD: begin
                        if (mod_next[3]) begin
                            q_data.code[n] = KC_ALT; q_data.down[n] = 1'b0; n = n + 1'b1;
                        end
                        mod_next[3] = 1'b0;
                    end
                    BTN_LTRIG: begin
                        if (mod_next[0]) begin
                            q_data.code[n] = KC_CTRL; q_data.down[n] = 1'b0; n = n + 1'b1;
                        end
                        mod_next[0] = 1'b0;
                    end
                    BTN_RTRIG: begin
                        if (mod_next[1]) begin
                            q_data.code[n] = KC_SHIFT; q_data.down[n] = 1'b0;
                            n = n + 1'b1;
                        end
                        mod_next[1] = 1'b0;
                    end
                    BTN_VIEW:    misc_next[0] = 1'b0;
                    BTN_OPTIONS: misc_next[1] = 1'b0;
                    default: ;
                endcase
            end else if (ek == MODE_HAT) begin
                if (ctl == AXIS_X) cb_next = cb_next & ~(DL | DR);
                else cb_next = cb_next & ~(DU | DD);
                pend_next = 1'b0;
            end else begin
                unique case (ctl)
                    AXIS_X: begin
                        if (misc_next[2]) begin
                            q_data.code[n] = KC_ARROW_LEFT; q_data.down[n] = 1'b0;
                            n = n + 1'b1;
                        end else if (misc_next[3]) begin
                            q_data.code[n] = KC_ARROW_RIGHT; q_data.down[n] = 1'b0;
                            n = n + 1'b1;
                        end
                        misc_next[3:2] = 2'b00;
                    end
                    AXIS_Y: begin
                        if (misc_next[4]) begin
                            q_data.code[n] = KC_ARROW_UP; q_data.down[n] = 1'b0;
                            n = n + 1'b1;
                        end else if (misc_next[5]) begin
                            q_data.code[n] = KC_ARROW_DOWN; q_data.down[n] = 1'b0;
                            n = n + 1'b1;
                        end
                        misc_next[5:4] = 2'b00;
                    end
                    AXIS_RX: misc_next[7:6] = 2'b00;
                    AXIS_RY: misc_next[9:8] = 2'b00;
                    default: ;
                endcase
            end
            if (cb_next == 8'd0 && mod_next == 4'd0 && misc_next == 10'd0 && !pend_next)
                side_next = SIDE_NONE;
        end

        if (prs) begin
            if (!kb_next) begin
                if (ek == MODE_BUTTON && ctl == BTN_PS) kb_next = 1'b1;
            end else begin
                if (side_next == SIDE_NONE) begin
                    if (ek == MODE_BUTTON && ctl < 4'd4) side_next = SIDE_R;
                    else if (ek == MODE_HAT) side_next = SIDE_L;
                end
                if (ek == MODE_BUTTON) begin
                    unique case (ctl)
                        BTN_FACE_S: begin cb_next = cb_next | FS; pend_next = 1'b1; end
                        BTN_FACE_E: begin cb_next = cb_next | FE; pend_next = 1'b1; end
                        BTN_FACE_N: begin cb_next = cb_next | FN; pend_next = 1'b1; end
                        BTN_FACE_W: begin cb_next = cb_next | FW; pend_next = 1'b1; end
                        BTN_LSHLD: begin
                            mod_next[2] = 1'b1;
                            q_data.code[n] = KC_META; q_data.down[n] = 1'b1; n = n + 1'b1;
                        end
                        BTN_RSHLD: begin
                            mod_next[3] = 1'b1;
                            q_data.code[n] = KC_ALT; q_data.down[n] = 1'b1; n = n + 1'b1;
                        end
                        BTN_LTRIG: begin
                            mod_next[0] = 1'b1;
                            q_data.code[n] = KC_CTRL; q_data.down[n] = 1'b1; n = n + 1'b1;
                        end
                        BTN_RTRIG: begin
                            mod_next[1] = 1'b1;
                            q_data.code[n] = KC_SHIFT; q_data.down[n] = 1'b1;
                            n = n + 1'b1;
                        end
                        BTN_VIEW:    misc_next[0] = 1'b1;
                        BTN_OPTIONS: misc_next[1] = 1'b1;
                        BTN_PS: begin
                            kb_next = 1'b0;
                            if (mod_next[0]) begin
                                q_data.code[n] = KC_CTRL; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            if (mod_next[1]) begin
                                q_data.code[n] = KC_SHIFT; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            if (mod_next[2]) begin
                                q_data.code[n] = KC_META; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            if (mod_next[3]) begin
                                q_data.code[n] = KC_ALT; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            if (misc_next[2]) begin
                                q_data.code[n] = KC_ARROW_LEFT; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end else if (misc_next[3]) begin
                                q_data.code[n] = KC_ARROW_RIGHT; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            if (misc_next[4]) begin
                                q_data.code[n] = KC_ARROW_UP; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end else if (misc_next[5]) begin
                                q_data.code[n] = KC_ARROW_DOWN; q_data.down[n] = 1'b0;
                                n = n + 1'b1;
                            end
                            cb_next = '0; mod_next = '0; misc_next = '0;
                            pend_next = 1'b0; side_next = SIDE_NONE;
                        end
                        default: ;
                    endcase
                end else if (ek == MODE_HAT) begin
                    if (ctl == AXIS_X) cb_next = cb_next | (neg ? DL : DR);
                    else cb_next = cb_next | (neg ? DU : DD);
                    pend_next = 1'b1;
                end else begin
                    unique case (ctl)
                        AXIS_X: begin
                            q_data.code[n] = neg ? KC_ARROW_LEFT : KC_ARROW_RIGHT;
                            q_data.down[n] = 1'b1; n = n + 1'b1;
                            if (neg) misc_next[2] = 1'b1; else misc_next[3] = 1'b1;
                        end
                        AXIS_Y: begin
                            q_data.code[n] = neg ? KC_ARROW_UP : KC_ARROW_DOWN;
                            q_data.down[n] = 1'b1; n = n + 1'b1;
                            if (neg) misc_next[4] = 1'b1; else misc_next[5] = 1'b1;
                        end
                        AXIS_RX: if (neg) misc_next[6] = 1'b1; else misc_next[7] = 1'b1;
                        AXIS_RY: if (neg) misc_next[8] = 1'b1; else misc_next[9] = 1'b1;
                        default: ;
                    endcase
                end
            end
        end
        q_data.cnt = n;
        q_push = accept && (n != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= 7'd64;
            hys_reg  <= 6'd20;
            kb_reg   <= 1'b0;
            cb_reg   <= '0;
            mod_reg  <= '0;
            misc_reg <= '0;
            pend_reg <= 1'b0;
            side_reg <= SIDE_NONE;
            for (int i = 0; i < STICK_AXES; i++) lvl_reg[i] <= 2'b00;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_THRESHOLD) thr_reg <= cfg_data[6:0];
                else if (cfg_index == REG_HYSTERESIS) hys_reg <= cfg_data[5:0];
            end
            if (accept) begin
                kb_reg   <= kb_next;
                cb_reg   <= cb_next;
                mod_reg  <= mod_next;
                misc_reg <= misc_next;
                pend_reg <= pend_next;
                side_reg <= side_next;
                if (lvl_we) lvl_reg[ctl[AXIS_W-1:0]] <= lvl_new;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/gckm_queue.sv
// gckm_queue: two-entry queue of key event lists between front and back
// depends on gckm_pkg
`default_nettype none
module gckm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire gckm_pkg::ev_bundle_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    out_valid,
    output gckm_pkg::ev_bundle_t    out_data
);
    import gckm_pkg::*;

    ev_bundle_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) wp_reg <= !wp_reg;
            if (pop && out_valid) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && out_valid) ? 1 : 0);
        end
    end

endmodule
`default_nettype wire

// File: rtl/gckm_back.sv
// gckm_back: drains one key event list per item onto the result stream
// depends on gckm_pkg
`default_nettype none
module gckm_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire gckm_pkg::ev_bundle_t q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);
    import gckm_pkg::*;

    ev_bundle_t      cur_reg;
    logic            vld_reg;
    logic [EV_W-1:0] idx_reg;
    logic            last;

    assign last     = (idx_reg == cur_reg.cnt - 1'b1);
    assign m_tvalid = vld_reg;
    assign m_tdata  = cur_reg.code[idx_reg];
    assign m_tuser  = cur_reg.down[idx_reg];
    assign m_tlast  = last;
    assign q_pop    = q_valid && (!vld_reg || (m_tready && last));

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else if (q_pop) begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end else if (vld_reg && m_tready) begin
            if (last) vld_reg <= 1'b0;
            else idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/gamepad_chord_keyboard_mapper_core.sv
// gamepad_chord_keyboard_mapper_core: top level, front classifier, event queue, back drain
// path: request to queue register to back end list register; one key event per cycle
// while m_tready is high; a new request each cycle while the two-entry queue has room
// the back end holds an item until all of its events are sent, up to six events per item
// reset: synchronous active-low, state cleared, threshold 64, hysteresis 20
`default_nettype none
module gamepad_chord_keyboard_mapper_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // mode[1:0], control[5:2], value[14:6]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // key_code[7:0]
    output logic             m_tuser,   // press flag
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import gckm_pkg::*;

    logic       q_full, q_push, q_pop, q_valid;
    ev_bundle_t q_in, q_out;

    gckm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    gckm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .out_valid(q_valid), .out_data(q_out)
    );

    gckm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_queue_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_out.cnt != '0))
        else $error("empty event list queued");
    a_drain_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !q_valid) |=> !m_tvalid)
        else $error("result after last with empty queue");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("request taken with full queue");

endmodule
`default_nettype wire
